### rtl/maze_flood_fill_planner_top_defines.svh
// ----------------------------------------------------------------------------
// maze flood fill planner assertion macros
// shared property templates for the checker
// ----------------------------------------------------------------------------
`ifndef MAZE_FLOOD_FILL_PLANNER_TOP_DEFINES_SVH
`define MAZE_FLOOD_FILL_PLANNER_TOP_DEFINES_SVH

// same-cycle implication
`define MFFP_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mffp assertion failed");

// next-cycle implication
`define MFFP_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mffp assertion failed");

`endif

### rtl/mffp_pkg.sv
// ----------------------------------------------------------------------------
// mffp_pkg
// types, constants and helpers of the maze flood fill planner
// ----------------------------------------------------------------------------
package mffp_pkg;

	localparam int MAZE_SIZE = 16;
	localparam logic [7:0] UNREACHABLE = 8'hFF;

	typedef enum logic [1:0] {
		CMD_SET_WALL = 2'd0,
		CMD_SENSOR   = 2'd1,
		CMD_MOVE     = 2'd2,
		CMD_RESTART  = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_START_HEADING = 3'd2;
	localparam logic [2:0] REG_GOAL_X = 3'd3;
	localparam logic [2:0] REG_GOAL_Y = 3'd4;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] cell_x;
		logic [3:0] cell_y;
		logic [1:0] wall_side;
		logic       wall_present;
		logic       sensor_front_left;
		logic       sensor_front_right;
		logic       sensor_left;
		logic       sensor_right;
		logic [1:0] move_heading;
	} req_t;

	typedef struct packed {
		logic [3:0] pos_x;
		logic [3:0] pos_y;
		logic [1:0] cur_heading;
		logic [1:0] best_heading;
		logic       escape_route;
		logic [7:0] here_distance;
	} rsp_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] x;
		logic [3:0] y;
	} step_t;

	// broadcast control from the sequencer to every row
	typedef struct packed {
		logic       clear_walls;
		logic       flood_init;
		logic       flood_step;
		logic [3:0] goal_x;
		logic [3:0] goal_y;
		logic [7:0] level;
	} row_ctl_t;

	// one wall write, own cell and the neighbor sharing it
	typedef struct packed {
		logic       en;
		logic [3:0] x;
		logic [3:0] y;
		logic [1:0] side;
		logic       present;
		logic       nen;
		logic [3:0] nx;
		logic [3:0] ny;
	} wall_wr_t;

	function automatic step_t step_cell(logic [3:0] x, logic [3:0] y, logic [1:0] d);
		step_t s;
		s.ok = 1'b1;
		s.x = x;
		s.y = y;
		case (d)
			DIR_N: begin
				if (y == 4'd0) s.ok = 1'b0;
				else s.y = y - 4'd1;
			end
			DIR_E: begin
				if ({1'b0, x} + 5'd1 >= 5'(MAZE_SIZE)) s.ok = 1'b0;
				else s.x = x + 4'd1;
			end
			DIR_S: begin
				if ({1'b0, y} + 5'd1 >= 5'(MAZE_SIZE)) s.ok = 1'b0;
				else s.y = y + 4'd1;
			end
			default: begin
				if (x == 4'd0) s.ok = 1'b0;
				else s.x = x - 4'd1;
			end
		endcase
		return s;
	endfunction

	function automatic logic [3:0] sat_coord(logic [3:0] v);
		return ({1'b0, v} >= 5'(MAZE_SIZE)) ? 4'(MAZE_SIZE - 1) : v;
	endfunction

endpackage

### rtl/mffp_row.sv
// ----------------------------------------------------------------------------
// mffp_row
// one maze row: wall bits, distances and the flood wavefront of its cells
// ----------------------------------------------------------------------------
module mffp_row (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [3:0]                       row_idx,
	input  mffp_pkg::row_ctl_t               ctl,
	input  mffp_pkg::wall_wr_t               wr,
	input  logic [mffp_pkg::MAZE_SIZE-1:0]   front_up,
	input  logic [mffp_pkg::MAZE_SIZE-1:0]   front_dn,
	input  logic [3:0]                       qx,
	output logic [mffp_pkg::MAZE_SIZE-1:0]   front,
	output logic [7:0]                       qdist,
	output logic [3:0]                       qwall
);

	logic [3:0] wall_q [mffp_pkg::MAZE_SIZE];
	logic [7:0] dist_q [mffp_pkg::MAZE_SIZE];
	logic [mffp_pkg::MAZE_SIZE-1:0] front_q;
	logic [mffp_pkg::MAZE_SIZE-1:0] front_nxt;
	logic [mffp_pkg::MAZE_SIZE-1:0] front_e;
	logic [mffp_pkg::MAZE_SIZE-1:0] front_w;

	// wavefront of the east and west neighbors
	assign front_e = {1'b0, front_q[mffp_pkg::MAZE_SIZE-1:1]};
	assign front_w = {front_q[mffp_pkg::MAZE_SIZE-2:0], 1'b0};

	always_comb begin
		for (int c = 0; c < mffp_pkg::MAZE_SIZE; c++) begin
			front_nxt[c] = (dist_q[c] == mffp_pkg::UNREACHABLE) &&
				((!wall_q[c][mffp_pkg::DIR_N] && front_up[c]) ||
				 (!wall_q[c][mffp_pkg::DIR_E] && front_e[c])  ||
				 (!wall_q[c][mffp_pkg::DIR_S] && front_dn[c]) ||
				 (!wall_q[c][mffp_pkg::DIR_W] && front_w[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < mffp_pkg::MAZE_SIZE; c++) wall_q[c] <= 4'd0;
		end else if (ctl.clear_walls) begin
			for (int c = 0; c < mffp_pkg::MAZE_SIZE; c++) wall_q[c] <= 4'd0;
		end else begin
			for (int c = 0; c < mffp_pkg::MAZE_SIZE; c++) begin
				if (wr.en && wr.y == row_idx && wr.x == 4'(c))
					wall_q[c][wr.side] <= wr.present;
				if (wr.nen && wr.ny == row_idx && wr.nx == 4'(c))
					wall_q[c][wr.side + 2'd2] <= wr.present;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
		end else if (ctl.flood_init) begin
			for (int c = 0; c < mffp_pkg::MAZE_SIZE; c++)
				front_q[c] <= (ctl.goal_y == row_idx) && (ctl.goal_x == 4'(c));
		end else if (ctl.flood_step) begin
			front_q <= front_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.flood_init) begin
			for (int c = 0; c < mffp_pkg::MAZE_SIZE; c++)
				dist_q[c] <= ((ctl.goal_y == row_idx) && (ctl.goal_x == 4'(c))) ?
					8'd0 : mffp_pkg::UNREACHABLE;
		end else if (ctl.flood_step) begin
			for (int c = 0; c < mffp_pkg::MAZE_SIZE; c++)
				if (front_nxt[c]) dist_q[c] <= ctl.level + 8'd1;
		end
	end

	assign front = front_q;
	assign qdist = dist_q[qx];
	assign qwall = wall_q[qx];

endmodule

### rtl/maze_flood_fill_planner_top.sv
// ----------------------------------------------------------------------------
// maze_flood_fill_planner_top
// micromouse flood fill planner built as a chain of maze rows
// ----------------------------------------------------------------------------
// channel   | ports                          | handshake
// ----------+--------------------------------+------------------------------
// request   | start, busy, req               | taken when start && !busy
// result    | rsp_valid, rsp                 | one-cycle strobe, no stall
// config    | cfg_we, cfg_addr, cfg_wdata    | written when cfg_we is high
//
// sequence: a move or out-of-grid wall queries the robot cell and its four
//   neighbors in S_EVAL, then strobes in S_OUT; a set wall runs S_INIT and
//   S_FLOOD first, sensor update adds S_SENS2 and S_SENS3 ahead, restart as set
//   wall; distances reach at most 255, one wavefront step per cycle across rows
// reset: walls clear and a flood from the default goal runs, busy high meanwhile
// the result side cannot stall; each request yields exactly one strobe
module maze_flood_fill_planner_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mffp_pkg::req_t   req,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [3:0]       cfg_wdata,
	output logic             rsp_valid,
	output mffp_pkg::rsp_t   rsp
);

	localparam int N = mffp_pkg::MAZE_SIZE;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SENS2 = 7'b0000010,
		S_SENS3 = 7'b0000100,
		S_INIT  = 7'b0001000,
		S_FLOOD = 7'b0010000,
		S_EVAL  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers, used only at restart
	logic [3:0] start_x_q, start_y_q, goal_x_cfg_q, goal_y_cfg_q;
	logic [1:0] start_h_q;

	// robot and latched goal
	logic [3:0] robot_x_q, robot_y_q, goal_x_q, goal_y_q;
	logic [1:0] robot_h_q;

	logic [7:0] level_q;
	logic [2:0] eval_cnt_q;
	logic       report_q;
	logic       sens_left_q, sens_right_q;

	// result accumulation
	logic [7:0] here_q, best_d_q;
	logic [3:0] walls_here_q;
	logic [1:0] best_q;
	logic       esc_q;

	logic accept;
	mffp_pkg::cmd_t cmd;
	logic in_range;

	mffp_pkg::row_ctl_t ctl;
	mffp_pkg::wall_wr_t wr;
	mffp_pkg::step_t    wstep, qstep, mstep;

	logic       pw_en, pw_present;
	logic [3:0] pw_x, pw_y;
	logic [1:0] pw_side;

	logic [N-1:0] front_row [N];
	logic [7:0]   qdist_row [N];
	logic [3:0]   qwall_row [N];
	logic [N-1:0] front_any_row;
	logic         any_front;

	logic [3:0] qx, qy;
	logic [1:0] eval_dir;
	logic [7:0] qd;

	assign accept   = start && (state_q == S_IDLE);
	assign cmd      = mffp_pkg::cmd_t'(req.command);
	assign in_range = ({1'b0, req.cell_x} < 5'(N)) && ({1'b0, req.cell_y} < 5'(N));
	assign busy     = (state_q != S_IDLE);

	// pick the one wall write of this cycle: set wall, or one of three sensor sides
	always_comb begin
		pw_en = 1'b0;
		pw_x = robot_x_q;
		pw_y = robot_y_q;
		pw_side = robot_h_q;
		pw_present = 1'b0;
		if (accept && cmd == mffp_pkg::CMD_SET_WALL && in_range) begin
			pw_en = 1'b1;
			pw_x = req.cell_x;
			pw_y = req.cell_y;
			pw_side = req.wall_side;
			pw_present = req.wall_present;
		end else if (accept && cmd == mffp_pkg::CMD_SENSOR) begin
			pw_en = 1'b1;
			pw_present = req.sensor_front_left | req.sensor_front_right;
		end else if (state_q == S_SENS2) begin
			pw_en = 1'b1;
			pw_side = robot_h_q + 2'd3;
			pw_present = sens_left_q;
		end else if (state_q == S_SENS3) begin
			pw_en = 1'b1;
			pw_side = robot_h_q + 2'd1;
			pw_present = sens_right_q;
		end
	end

	assign wstep = mffp_pkg::step_cell(pw_x, pw_y, pw_side);

	always_comb begin
		wr.en = pw_en;
		wr.x = pw_x;
		wr.y = pw_y;
		wr.side = pw_side;
		wr.present = pw_present;
		wr.nen = pw_en && wstep.ok;
		wr.nx = wstep.x;
		wr.ny = wstep.y;
	end

	// flood control broadcast to the rows
	always_comb begin
		ctl.clear_walls = accept && (cmd == mffp_pkg::CMD_RESTART);
		ctl.flood_init = (state_q == S_INIT);
		ctl.flood_step = (state_q == S_FLOOD) && any_front && (level_q != 8'hFF);
		ctl.goal_x = goal_x_q;
		ctl.goal_y = goal_y_q;
		ctl.level = level_q;
	end

	// query address: robot cell first, then its four neighbors in n, e, s, w order
	assign eval_dir = 2'(eval_cnt_q - 3'd1);
	assign qstep = mffp_pkg::step_cell(robot_x_q, robot_y_q, eval_dir);
	assign qx = (eval_cnt_q == 3'd0) ? robot_x_q : qstep.x;
	assign qy = (eval_cnt_q == 3'd0) ? robot_y_q : qstep.y;
	assign qd = qdist_row[qy];

	assign mstep = mffp_pkg::step_cell(robot_x_q, robot_y_q, req.move_heading);

	// chain of rows, each handing its wavefront to the rows above and below
	for (genvar r = 0; r < N; r++) begin : g_row
		logic [N-1:0] up, dn;
		if (r == 0) begin : g_top
			assign up = '0;
		end else begin : g_mid_up
			assign up = front_row[r-1];
		end
		if (r == N - 1) begin : g_bot
			assign dn = '0;
		end else begin : g_mid_dn
			assign dn = front_row[r+1];
		end
		mffp_row u_row (
			.clk      (clk),
			.arst_n   (arst_n),
			.row_idx  (4'(r)),
			.ctl      (ctl),
			.wr       (wr),
			.front_up (up),
			.front_dn (dn),
			.qx       (qx),
			.front    (front_row[r]),
			.qdist    (qdist_row[r]),
			.qwall    (qwall_row[r])
		);
		assign front_any_row[r] = |front_row[r];
	end

	assign any_front = |front_any_row;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= 4'd0;
			start_y_q <= 4'd0;
			start_h_q <= 2'd0;
			goal_x_cfg_q <= 4'd7;
			goal_y_cfg_q <= 4'd7;
		end else if (cfg_we) begin
			case (cfg_addr)
				mffp_pkg::REG_START_X:       start_x_q <= cfg_wdata;
				mffp_pkg::REG_START_Y:       start_y_q <= cfg_wdata;
				mffp_pkg::REG_START_HEADING: start_h_q <= cfg_wdata[1:0];
				mffp_pkg::REG_GOAL_X:        goal_x_cfg_q <= cfg_wdata;
				mffp_pkg::REG_GOAL_Y:        goal_y_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			robot_x_q <= mffp_pkg::sat_coord(4'd0);
			robot_y_q <= mffp_pkg::sat_coord(4'd0);
			robot_h_q <= 2'd0;
			goal_x_q <= mffp_pkg::sat_coord(4'd7);
			goal_y_q <= mffp_pkg::sat_coord(4'd7);
			level_q <= 8'd0;
			eval_cnt_q <= 3'd0;
			report_q <= 1'b0;
			sens_left_q <= 1'b0;
			sens_right_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						report_q <= 1'b1;
						eval_cnt_q <= 3'd0;
						case (cmd)
							mffp_pkg::CMD_SET_WALL: begin
								state_q <= in_range ? S_INIT : S_EVAL;
							end
							mffp_pkg::CMD_SENSOR: begin
								sens_left_q <= req.sensor_left;
								sens_right_q <= req.sensor_right;
								state_q <= S_SENS2;
							end
							mffp_pkg::CMD_MOVE: begin
								if (mstep.ok) begin
									robot_x_q <= mstep.x;
									robot_y_q <= mstep.y;
									robot_h_q <= req.move_heading;
								end
								state_q <= S_EVAL;
							end
							default: begin
								robot_x_q <= mffp_pkg::sat_coord(start_x_q);
								robot_y_q <= mffp_pkg::sat_coord(start_y_q);
								robot_h_q <= start_h_q;
								goal_x_q <= mffp_pkg::sat_coord(goal_x_cfg_q);
								goal_y_q <= mffp_pkg::sat_coord(goal_y_cfg_q);
								state_q <= S_INIT;
							end
						endcase
					end
				end
				S_SENS2: state_q <= S_SENS3;
				S_SENS3: state_q <= S_INIT;
				S_INIT: begin
					level_q <= 8'd0;
					state_q <= S_FLOOD;
				end
				S_FLOOD: begin
					// stop once the wavefront dies out or the level reaches 8'hFF
					if (!any_front || level_q == 8'hFF) begin
						eval_cnt_q <= 3'd0;
						state_q <= S_EVAL;
					end else begin
						level_q <= level_q + 8'd1;
					end
				end
				S_EVAL: begin
					if (eval_cnt_q == 3'd4) begin
						state_q <= report_q ? S_OUT : S_IDLE;
					end else begin
						eval_cnt_q <= eval_cnt_q + 3'd1;
					end
				end
				S_OUT: begin
					report_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// neighbor scan: strictly lower distance wins, first in n, e, s, w order
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			if (eval_cnt_q == 3'd0) begin
				here_q <= qd;
				walls_here_q <= qwall_row[qy];
				best_q <= robot_h_q;
				best_d_q <= mffp_pkg::UNREACHABLE;
				esc_q <= 1'b0;
			end else if (qstep.ok && !walls_here_q[eval_dir]) begin
				if (qd < here_q) esc_q <= 1'b1;
				if (qd < best_d_q) begin
					best_d_q <= qd;
					best_q <= eval_dir;
				end
			end
		end
	end

	assign rsp_valid = (state_q == S_OUT);

	always_comb begin
		rsp.pos_x = robot_x_q;
		rsp.pos_y = robot_y_q;
		rsp.cur_heading = robot_h_q;
		rsp.best_heading = best_q;
		rsp.escape_route = esc_q;
		rsp.here_distance = here_q;
	end

endmodule

### rtl/mffp_checker.sv
// ----------------------------------------------------------------------------
// mffp_checker
// port-level checks of the maze flood fill planner
// ----------------------------------------------------------------------------
`include "maze_flood_fill_planner_top_defines.svh"

module mffp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           rsp_valid,
	input mffp_pkg::rsp_t rsp
);

	// a result is only shown while the request is still in flight
	`MFFP_ASSERT_NOW(a_rsp_while_busy, rsp_valid, busy)
	// a taken request always makes the block busy
	`MFFP_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	// one strobe per request
	`MFFP_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
	// nothing lies below the goal
	`MFFP_ASSERT_NOW(a_goal_no_escape, rsp_valid && rsp.here_distance == 8'd0, !rsp.escape_route)

endmodule

bind maze_flood_fill_planner_top mffp_checker u_mffp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);
